// ----- hw/rtl/emam_pkg.sv -----
// Shared types, constants and register codes of the EMA alarm monitor.
package emam_pkg;

   localparam int AVG_EXTRA_FRAC_BITS = 8;
   localparam int NUM_CH              = 4;
   localparam int READ_W              = 16;
   localparam int ACC_W               = READ_W + AVG_EXTRA_FRAC_BITS;
   localparam int CNT_W               = 32;
   localparam int CSR_ADDR_W          = 3;

   // Divide by ten: bias the sum non-negative, then scale by a rounded-up reciprocal.
   localparam int EMA_DIVISOR = 10;
   localparam int SUM_W       = ACC_W + 4;
   localparam int DIV_SHIFT   = SUM_W + 4;
   localparam int RECIP_W     = SUM_W + 1;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(EMA_DIVISOR - 1)) / 64'(EMA_DIVISOR));
   localparam logic [SUM_W-1:0] DIV_OFFSET = SUM_W'(EMA_DIVISOR) << ACC_W;

   typedef logic signed [READ_W-1:0] reading_type;
   typedef logic signed [ACC_W-1:0]  acc_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [1:0]               chan_type;

   localparam chan_type CH_COOLANT   = 2'd0;
   localparam chan_type CH_OIL_TEMP  = 2'd1;
   localparam chan_type CH_OIL_PRESS = 2'd2;
   localparam chan_type CH_BATTERY   = 2'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COOLANT_LIMIT   = 3'd0,
      CSR_OIL_TEMP_LIMIT  = 3'd1,
      CSR_OIL_PRESS_LIMIT = 3'd2,
      CSR_BATTERY_LIMIT   = 3'd3,
      CSR_MONITOR_RUNNING = 3'd4
   } csr_addr_type;

   localparam reading_type COOLANT_LIMIT_RST   = 16'sd1760;
   localparam reading_type OIL_TEMP_LIMIT_RST  = 16'sd1920;
   localparam reading_type OIL_PRESS_LIMIT_RST = 16'sd1600;
   localparam reading_type BATTERY_LIMIT_RST   = 16'sd160;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_CLEAR  = 1'b1;

   typedef struct packed {
      logic        action;
      reading_type coolant_sample;
      reading_type oil_temp_sample;
      reading_type oil_press_sample;
      reading_type battery_sample;
   } req_payload_type;

   typedef struct packed {
      logic        active;
      logic        any_alarm;
      logic [3:0]  alarm_mask;
      chan_type    alarm_channel;
      reading_type alarm_value;
      reading_type coolant_average;
      reading_type oil_temp_average;
      reading_type oil_press_average;
      reading_type battery_average;
      count_type   sample_index;
      count_type   alarm_event_count;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/emam_if.sv -----
// Valid/ready channel interfaces: sample requests, results and register writes.
interface emam_req_if;
   logic                     valid;
   logic                     ready;
   emam_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface emam_rsp_if;
   logic                     valid;
   logic                     ready;
   emam_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface emam_csr_if;
   logic                              valid;
   logic                              ready;
   logic [emam_pkg::CSR_ADDR_W-1:0]   addr;
   logic [emam_pkg::READ_W-1:0]       wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ----- hw/rtl/emam_ema_update.sv -----
// One channel's 0.9/0.1 exponential average step: floor((9*acc + sample*scale)/10).
module emam_ema_update (
   input  emam_pkg::acc_type     acc,
   input  emam_pkg::reading_type sample,
   output emam_pkg::acc_type     acc_next
);

   logic signed [emam_pkg::SUM_W-1:0] acc_ext;
   logic signed [emam_pkg::SUM_W-1:0] acc_x9;
   logic signed [emam_pkg::SUM_W-1:0] samp_ext;
   logic signed [emam_pkg::SUM_W-1:0] sum;
   logic        [emam_pkg::SUM_W-1:0] biased;
   logic        [emam_pkg::PROD_W-1:0] prod;

   always_comb begin
      acc_ext  = emam_pkg::SUM_W'(acc);
      acc_x9   = (acc_ext <<< 3) + acc_ext;
      samp_ext = emam_pkg::SUM_W'(sample) <<< emam_pkg::AVG_EXTRA_FRAC_BITS;
      sum      = acc_x9 + samp_ext;
      // offset is a multiple of ten, so floor division survives the bias
      biased   = unsigned'(sum) + emam_pkg::DIV_OFFSET;
      prod     = emam_pkg::PROD_W'(biased) * emam_pkg::PROD_W'(emam_pkg::DIV_RECIP);
      // quotient minus offset/10 (= 2^ACC_W) is just the low ACC_W bits
      acc_next = signed'(prod[emam_pkg::DIV_SHIFT +: emam_pkg::ACC_W]);
   end

endmodule

// ----- hw/rtl/four_channel_ema_alarm_monitor.sv -----
// Top level of the four-channel EMA alarm monitor.
//
// Channels (valid/ready, a transfer happens when both are high):
//   req_chan - one request per sample set: action (0 sample, 1 clear counters)
//              and four signed Q12.4 readings.
//   rsp_chan - one result per request: active flag, alarm mask/channel/value,
//              four Q12.4 averages, sample index and alarm event count.
//   csr_chan - register writes (limits, running flag); always ready, index
//              values past the register list are dropped.
// Timing: a request is captured in the input register, and from there the
//   average, limit compare and counter logic runs combinationally into the
//   result register, which drives rsp valid; one request per cycle is
//   sustained while the result channel is ready. The per-channel
//   divide-by-ten reciprocal multiplier lies on this path and also feeds
//   the average registers.
// Reset (synchronous, active high): averages and counters go to zero, limits
//   to their defaults, running flag to 0, both pipeline stages empty.
// Stall: a held result keeps its register; the input register still takes one
//   more request, then req ready drops until the result is taken.
module four_channel_ema_alarm_monitor (
   input  logic              clock,
   input  logic              reset,
   emam_req_if.sink          req_chan,
   emam_rsp_if.source        rsp_chan,
   emam_csr_if.sink          csr_chan
);

   // ---------------- configuration registers ----------------
   emam_pkg::reading_type coolant_limit_ff, coolant_limit_in;
   emam_pkg::reading_type oil_temp_limit_ff, oil_temp_limit_in;
   emam_pkg::reading_type oil_press_limit_ff, oil_press_limit_in;
   emam_pkg::reading_type battery_limit_ff, battery_limit_in;
   logic                  running_ff, running_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      coolant_limit_in   = coolant_limit_ff;
      oil_temp_limit_in  = oil_temp_limit_ff;
      oil_press_limit_in = oil_press_limit_ff;
      battery_limit_in   = battery_limit_ff;
      running_in         = running_ff;
      if (csr_chan.valid && csr_chan.ready) begin
         case (emam_pkg::csr_addr_type'(csr_chan.addr))
            emam_pkg::CSR_COOLANT_LIMIT:   coolant_limit_in   = signed'(csr_chan.wdata);
            emam_pkg::CSR_OIL_TEMP_LIMIT:  oil_temp_limit_in  = signed'(csr_chan.wdata);
            emam_pkg::CSR_OIL_PRESS_LIMIT: oil_press_limit_in = signed'(csr_chan.wdata);
            emam_pkg::CSR_BATTERY_LIMIT:   battery_limit_in   = signed'(csr_chan.wdata);
            emam_pkg::CSR_MONITOR_RUNNING: running_in         = csr_chan.wdata[0];
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coolant_limit_ff   <= emam_pkg::COOLANT_LIMIT_RST;
         oil_temp_limit_ff  <= emam_pkg::OIL_TEMP_LIMIT_RST;
         oil_press_limit_ff <= emam_pkg::OIL_PRESS_LIMIT_RST;
         battery_limit_ff   <= emam_pkg::BATTERY_LIMIT_RST;
         running_ff         <= 1'b0;
      end else begin
         coolant_limit_ff   <= coolant_limit_in;
         oil_temp_limit_ff  <= oil_temp_limit_in;
         oil_press_limit_ff <= oil_press_limit_in;
         battery_limit_ff   <= battery_limit_in;
         running_ff         <= running_in;
      end
   end

   // ---------------- input register ----------------
   logic                      in_valid_ff, in_valid_in;
   emam_pkg::req_payload_type in_data_ff, in_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   emam_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;
   logic                      advance;
   logic                      req_take;

   // the stage moves when the result register is empty or being drained
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      in_data_in  = req_take ? req_chan.data : in_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   // ---------------- compute stage ----------------
   emam_pkg::acc_type     acc_ff   [emam_pkg::NUM_CH];
   emam_pkg::acc_type     acc_in   [emam_pkg::NUM_CH];
   emam_pkg::acc_type     acc_upd  [emam_pkg::NUM_CH];
   emam_pkg::reading_type samples  [emam_pkg::NUM_CH];
   emam_pkg::count_type   sample_cnt_ff, sample_cnt_in;
   emam_pkg::count_type   alarm_cnt_ff, alarm_cnt_in;
   logic [3:0]            mask;
   emam_pkg::chan_type    chan;
   emam_pkg::reading_type value;
   logic                  is_clear;

   assign samples[0] = in_data_ff.coolant_sample;
   assign samples[1] = in_data_ff.oil_temp_sample;
   assign samples[2] = in_data_ff.oil_press_sample;
   assign samples[3] = in_data_ff.battery_sample;

   for (genvar g = 0; g < emam_pkg::NUM_CH; g++) begin : g_ema
      emam_ema_update u_upd (
         .acc      (acc_ff[g]),
         .sample   (samples[g]),
         .acc_next (acc_upd[g])
      );
   end

   assign is_clear = (in_data_ff.action == emam_pkg::ACTION_CLEAR);

   always_comb begin
      // temperatures alarm above their limit, pressure and battery below
      mask[0] = samples[0] > coolant_limit_ff;
      mask[1] = samples[1] > oil_temp_limit_ff;
      mask[2] = samples[2] < oil_press_limit_ff;
      mask[3] = samples[3] < battery_limit_ff;
      if (is_clear) begin
         mask = 4'd0;
      end
      // first set bit wins: coolant, oil temp, oil pressure, battery
      if (mask[0]) begin
         chan  = emam_pkg::CH_COOLANT;
         value = samples[0];
      end else if (mask[1]) begin
         chan  = emam_pkg::CH_OIL_TEMP;
         value = samples[1];
      end else if (mask[2]) begin
         chan  = emam_pkg::CH_OIL_PRESS;
         value = samples[2];
      end else if (mask[3]) begin
         chan  = emam_pkg::CH_BATTERY;
         value = samples[3];
      end else begin
         chan  = emam_pkg::CH_COOLANT;
         value = '0;
      end
   end

   always_comb begin
      sample_cnt_in = sample_cnt_ff;
      alarm_cnt_in  = alarm_cnt_ff;
      for (int i = 0; i < emam_pkg::NUM_CH; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (advance) begin
         if (is_clear) begin
            sample_cnt_in = '0;
            alarm_cnt_in  = '0;
         end else begin
            for (int i = 0; i < emam_pkg::NUM_CH; i++) begin
               acc_in[i] = acc_upd[i];
            end
            sample_cnt_in = sample_cnt_ff + 1'b1;
            if (mask != 4'd0) begin
               alarm_cnt_in = alarm_cnt_ff + 1'b1;
            end
         end
      end

      rsp_data_in = rsp_data_ff;
      if (advance) begin
         rsp_data_in.active            = running_ff;
         rsp_data_in.any_alarm         = (mask != 4'd0);
         rsp_data_in.alarm_mask        = mask;
         rsp_data_in.alarm_channel     = chan;
         rsp_data_in.alarm_value       = value;
         // Q12.4 view is the top READ_W bits (floor of the extra fraction)
         rsp_data_in.coolant_average   = acc_in[0][emam_pkg::ACC_W-1 -: emam_pkg::READ_W];
         rsp_data_in.oil_temp_average  = acc_in[1][emam_pkg::ACC_W-1 -: emam_pkg::READ_W];
         rsp_data_in.oil_press_average = acc_in[2][emam_pkg::ACC_W-1 -: emam_pkg::READ_W];
         rsp_data_in.battery_average   = acc_in[3][emam_pkg::ACC_W-1 -: emam_pkg::READ_W];
         rsp_data_in.sample_index      = is_clear ? '0 : sample_cnt_ff;
         rsp_data_in.alarm_event_count = alarm_cnt_in;
      end
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < emam_pkg::NUM_CH; i++) begin
            acc_ff[i] <= '0;
         end
         sample_cnt_ff <= '0;
         alarm_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         for (int i = 0; i < emam_pkg::NUM_CH; i++) begin
            acc_ff[i] <= acc_in[i];
         end
         sample_cnt_ff <= sample_cnt_in;
         alarm_cnt_ff  <= alarm_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// ----- hw/rtl/emam_checker.sv -----
// Port-level checks of the EMA alarm monitor, bound to the top level.
module emam_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input emam_pkg::rsp_payload_type rsp_data
);

   // result channel: a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_any_alarm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.any_alarm == (rsp_data.alarm_mask != 4'd0))
      else $error("any_alarm disagrees with alarm_mask");

   a_no_alarm_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_alarm |->
         rsp_data.alarm_channel == emam_pkg::CH_COOLANT && rsp_data.alarm_value == '0)
      else $error("channel or value set without an alarm");

endmodule

bind four_channel_ema_alarm_monitor emam_checker u_emam_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// ----- verif/four_channel_ema_alarm_monitor_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: random valid/ready traffic, EMA and alarm prediction, per-field compare.
module four_channel_ema_alarm_monitor_tb;
   import emam_pkg::*;

   // Register indexes at and above this one are not mapped and must be dropped.
   localparam int NUM_REGS         = int'(CSR_MONITOR_RUNNING) + 1;
   localparam int PHASES           = 8;    // one limit setting per phase
   localparam int ITEMS_PER_PHASE  = 230;  // random requests per phase
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_CYCLES = 64;   // receiver back-pressure stretch

   localparam reading_type READ_MAX = 16'sh7FFF;
   localparam reading_type READ_MIN = 16'sh8000;

   logic clock;
   logic reset;

   emam_req_if req_bus ();
   emam_rsp_if rsp_bus ();
   emam_csr_if csr_bus ();

   four_channel_ema_alarm_monitor i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Shadow copy of the block: averages with extra fraction bits, counters,
   // limits (indexed by channel) and the running flag.
   acc_type     avg_acc [NUM_CH];
   count_type   sample_tally;
   count_type   alarm_count;
   reading_type limit_reg [NUM_CH];
   logic        running_reg;

   req_payload_type pending_requests [$];  // filled by the sequence, drained by the driver
   rsp_payload_type expected_results [$];  // one entry per accepted request

   bit idle_mode;      // random gaps on both sides when set
   bit hold_trigger;   // toggled by the sequence to start a long receiver hold
   bit hold_seen;
   int send_gap;
   int stall_left;
   int hold_left;

   int error_count;
   int requests_sent;
   int results_checked;
   int clears_sent;
   int alarms_seen;
   int reg_writes;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs a handshake.
   initial begin
      #10ms;
      $display("four_channel_ema_alarm_monitor_tb: errors");
      $finish;
   end

   // Gap length: mostly none, some short, a few long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Next result of the block for one accepted request; advances the shadow state.
   function automatic rsp_payload_type ema_alarm_predict(req_payload_type r);
      rsp_payload_type res;
      reading_type     rd [NUM_CH];
      longint          num;
      longint          quo;
      int              i;
      res = '0;
      rd[CH_COOLANT]   = r.coolant_sample;
      rd[CH_OIL_TEMP]  = r.oil_temp_sample;
      rd[CH_OIL_PRESS] = r.oil_press_sample;
      rd[CH_BATTERY]   = r.battery_sample;
      if (r.action == ACTION_CLEAR) begin
         // counters drop to zero, averages stay, readings are ignored
         sample_tally = '0;
         alarm_count  = '0;
      end else begin
         // acc = floor((9*acc + reading*2^F) / 10); SV division truncates, so fix negatives
         for (i = 0; i < NUM_CH; i++) begin
            num = longint'(EMA_DIVISOR - 1) * longint'(avg_acc[i])
                  + (longint'(rd[i]) <<< AVG_EXTRA_FRAC_BITS);
            quo = num / EMA_DIVISOR;
            if ((num % EMA_DIVISOR) != 0 && num < 0)
               quo = quo - 1;
            avg_acc[i] = acc_type'(quo);
         end
         // temperatures alarm above the limit, pressure and battery below it
         res.alarm_mask[CH_COOLANT]   = rd[CH_COOLANT]   > limit_reg[CH_COOLANT];
         res.alarm_mask[CH_OIL_TEMP]  = rd[CH_OIL_TEMP]  > limit_reg[CH_OIL_TEMP];
         res.alarm_mask[CH_OIL_PRESS] = rd[CH_OIL_PRESS] < limit_reg[CH_OIL_PRESS];
         res.alarm_mask[CH_BATTERY]   = rd[CH_BATTERY]   < limit_reg[CH_BATTERY];
         // lowest set bit wins
         for (i = NUM_CH - 1; i >= 0; i--) begin
            if (res.alarm_mask[i]) begin
               res.alarm_channel = chan_type'(i);
               res.alarm_value   = rd[i];
            end
         end
         res.any_alarm    = |res.alarm_mask;
         res.sample_index = sample_tally;
         sample_tally     = sample_tally + 1'b1;
         if (res.any_alarm)
            alarm_count = alarm_count + 1'b1;
      end
      res.active            = running_reg;
      res.alarm_event_count = alarm_count;
      // shown value is floor(acc / 2^F)
      res.coolant_average   = reading_type'(avg_acc[CH_COOLANT]   >>> AVG_EXTRA_FRAC_BITS);
      res.oil_temp_average  = reading_type'(avg_acc[CH_OIL_TEMP]  >>> AVG_EXTRA_FRAC_BITS);
      res.oil_press_average = reading_type'(avg_acc[CH_OIL_PRESS] >>> AVG_EXTRA_FRAC_BITS);
      res.battery_average   = reading_type'(avg_acc[CH_BATTERY]   >>> AVG_EXTRA_FRAC_BITS);
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                   results_checked, name, got, want));
   endtask

   task automatic check_result(rsp_payload_type got, rsp_payload_type want);
      check_field("active",            got.active,            want.active);
      check_field("any_alarm",         got.any_alarm,         want.any_alarm);
      check_field("alarm_mask",        got.alarm_mask,        want.alarm_mask);
      check_field("alarm_channel",     got.alarm_channel,     want.alarm_channel);
      check_field("alarm_value",       got.alarm_value,       want.alarm_value);
      check_field("coolant_average",   got.coolant_average,   want.coolant_average);
      check_field("oil_temp_average",  got.oil_temp_average,  want.oil_temp_average);
      check_field("oil_press_average", got.oil_press_average, want.oil_press_average);
      check_field("battery_average",   got.battery_average,   want.battery_average);
      check_field("sample_index",      got.sample_index,      want.sample_index);
      check_field("alarm_event_count", got.alarm_event_count, want.alarm_event_count);
   endtask

   // One register write; valid stays high so back-to-back writes need no extra edge.
   // Called at a rising edge, returns at the edge of the handshake.
   task automatic write_reg(logic [CSR_ADDR_W-1:0] index, logic [READ_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= index;
      csr_bus.wdata <= value;
      do @(posedge clock); while (!csr_bus.ready);
      reg_writes++;
      case (index)
         CSR_COOLANT_LIMIT:   limit_reg[CH_COOLANT]   = value;
         CSR_OIL_TEMP_LIMIT:  limit_reg[CH_OIL_TEMP]  = value;
         CSR_OIL_PRESS_LIMIT: limit_reg[CH_OIL_PRESS] = value;
         CSR_BATTERY_LIMIT:   limit_reg[CH_BATTERY]   = value;
         CSR_MONITOR_RUNNING: running_reg             = value[0];
         default: ;  // unmapped, dropped
      endcase
   endtask

   // Full register setting; only called with the block idle.
   task automatic load_settings(reading_type coolant, reading_type oil_temp,
                                reading_type oil_press, reading_type battery,
                                logic run, bit with_unmapped);
      logic [READ_W-1:0] run_word;
      int                a;
      run_word    = READ_W'($urandom);  // upper bits are don't-care, exercise them
      run_word[0] = run;
      @(posedge clock);
      write_reg(CSR_COOLANT_LIMIT, coolant);
      write_reg(CSR_OIL_TEMP_LIMIT, oil_temp);
      if (with_unmapped) begin
         for (a = NUM_REGS; a < (1 << CSR_ADDR_W); a++)
            write_reg(CSR_ADDR_W'(a), READ_W'($urandom));
      end
      write_reg(CSR_OIL_PRESS_LIMIT, oil_press);
      write_reg(CSR_BATTERY_LIMIT, battery);
      write_reg(CSR_MONITOR_RUNNING, run_word);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic push_sample(logic action, int coolant, int oil_temp, int oil_press,
                              int battery);
      req_payload_type r;
      r.action           = action;
      r.coolant_sample   = READ_W'(coolant);
      r.oil_temp_sample  = READ_W'(oil_temp);
      r.oil_press_sample = READ_W'(oil_press);
      r.battery_sample   = READ_W'(battery);
      pending_requests.push_back(r);
   endtask

   // Reading biased toward the channel's limit and the range ends.
   function automatic int random_reading(reading_type limit);
      case ($urandom_range(0, 9))
         4, 5, 6: return int'(limit) + $urandom_range(0, 8) - 4;
         7:       return READ_MAX;
         8:       return READ_MIN;
         default: return int'(reading_type'($urandom));
      endcase
   endfunction

   // Request driver: holds each request until accepted, then optionally idles.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_bus.data  <= pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            send_gap = idle_mode ? pick_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stalls, plus a long hold whenever the trigger toggles.
   // During the hold the block's two stages fill and req ready must drop.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
         hold_seen  = hold_trigger;
      end else begin
         if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_mode && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Monitor: check results against the oldest prediction, predict each accepted request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0)
               report_mismatch($sformatf("result %0d arrived with nothing pending",
                                         results_checked));
            else
               check_result(rsp_bus.data, expected_results.pop_front());
            results_checked++;
         end
         if (req_bus.valid && req_bus.ready) begin
            expected_results.push_back(ema_alarm_predict(req_bus.data));
            requests_sent++;
            if (req_bus.data.action == ACTION_CLEAR)
               clears_sent++;
            else if (expected_results[$].any_alarm)
               alarms_seen++;
         end
      end
   end

   // Sequence: directed set under reset defaults, then one random batch per limit setting.
   initial begin
      int p;
      int i;
      reset         = 1'b1;
      idle_mode     = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr  = '0;
      csr_bus.wdata = '0;
      for (i = 0; i < NUM_CH; i++)
         avg_acc[i] = '0;
      sample_tally            = '0;
      alarm_count             = '0;
      limit_reg[CH_COOLANT]   = COOLANT_LIMIT_RST;
      limit_reg[CH_OIL_TEMP]  = OIL_TEMP_LIMIT_RST;
      limit_reg[CH_OIL_PRESS] = OIL_PRESS_LIMIT_RST;
      limit_reg[CH_BATTERY]   = BATTERY_LIMIT_RST;
      running_reg             = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: ;  // reset defaults, running flag low
            // limits jittered around the defaults
            1: load_settings(READ_W'(COOLANT_LIMIT_RST + $urandom_range(0, 64) - 32),
                             READ_W'(OIL_TEMP_LIMIT_RST + $urandom_range(0, 64) - 32),
                             READ_W'(OIL_PRESS_LIMIT_RST + $urandom_range(0, 64) - 32),
                             READ_W'(BATTERY_LIMIT_RST + $urandom_range(0, 64) - 32),
                             1'b1, 1'b0);
            // no reading can ever be critical; unmapped indexes written too
            2: load_settings(READ_MAX, READ_MAX, READ_MIN, READ_MIN, 1'b0, 1'b1);
            // almost every reading critical
            3: load_settings(READ_MIN, READ_MIN, READ_MAX, READ_MAX, 1'b1, 1'b0);
            default: load_settings(reading_type'($urandom), reading_type'($urandom),
                                   reading_type'($urandom), reading_type'($urandom),
                                   1'($urandom_range(0, 1)), 1'b0);
         endcase
         @(negedge clock);
         // phases 1 and 4 run without gaps; phases 1 and 5 carry a long hold
         idle_mode = (p != 1 && p != 4);

         if (p == 0) begin
            push_sample(ACTION_SAMPLE, 0, 0, 0, 0);
            push_sample(ACTION_SAMPLE, 1000, 1000, 3000, 200);
            // readings right at the limits are not critical
            push_sample(ACTION_SAMPLE, COOLANT_LIMIT_RST, OIL_TEMP_LIMIT_RST,
                        OIL_PRESS_LIMIT_RST, BATTERY_LIMIT_RST);
            // one step past each limit, one channel at a time
            push_sample(ACTION_SAMPLE, COOLANT_LIMIT_RST + 1, OIL_TEMP_LIMIT_RST,
                        OIL_PRESS_LIMIT_RST, BATTERY_LIMIT_RST);
            push_sample(ACTION_SAMPLE, COOLANT_LIMIT_RST, OIL_TEMP_LIMIT_RST + 1,
                        OIL_PRESS_LIMIT_RST, BATTERY_LIMIT_RST);
            push_sample(ACTION_SAMPLE, COOLANT_LIMIT_RST, OIL_TEMP_LIMIT_RST,
                        OIL_PRESS_LIMIT_RST - 1, BATTERY_LIMIT_RST);
            push_sample(ACTION_SAMPLE, COOLANT_LIMIT_RST, OIL_TEMP_LIMIT_RST,
                        OIL_PRESS_LIMIT_RST, BATTERY_LIMIT_RST - 1);
            // all critical: coolant must win
            push_sample(ACTION_SAMPLE, READ_MAX, READ_MAX, READ_MIN, READ_MIN);
            // drive averages toward the top of the range, then the bottom
            repeat (5) push_sample(ACTION_SAMPLE, READ_MAX, READ_MAX, READ_MAX, READ_MAX);
            push_sample(ACTION_CLEAR, $urandom, $urandom, $urandom, $urandom);
            repeat (5) push_sample(ACTION_SAMPLE, READ_MIN, READ_MIN, READ_MIN, READ_MIN);
            push_sample(ACTION_CLEAR, READ_MIN, READ_MAX, READ_MIN, READ_MAX);
            push_sample(ACTION_SAMPLE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
            push_sample(ACTION_SAMPLE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
            push_sample(ACTION_SAMPLE, -1, -1, -1, -1);
         end

         repeat (ITEMS_PER_PHASE) begin
            push_sample(($urandom_range(0, 39) == 0) ? ACTION_CLEAR : ACTION_SAMPLE,
                        random_reading(limit_reg[CH_COOLANT]),
                        random_reading(limit_reg[CH_OIL_TEMP]),
                        random_reading(limit_reg[CH_OIL_PRESS]),
                        random_reading(limit_reg[CH_BATTERY]));
         end
         if (p == 1 || p == 5)
            hold_trigger = !hold_trigger;

         // idle before the next register setting
         while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
            @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
      end

      $display("Ran %0d requests (%0d counter clears, %0d alarm samples), %0d results checked",
               requests_sent, clears_sent, alarms_seen, results_checked);
      $display("%0d register writes over %0d limit settings, with receiver hold-offs",
               reg_writes, PHASES);
      if (error_count == 0) begin
         $display("four_channel_ema_alarm_monitor_tb: clean");
      end else begin
         $display("four_channel_ema_alarm_monitor_tb: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/emam_pkg.sv
hw/rtl/emam_if.sv
hw/rtl/emam_ema_update.sv
hw/rtl/four_channel_ema_alarm_monitor.sv
hw/rtl/emam_checker.sv
verif/four_channel_ema_alarm_monitor_tb.sv
